// ----- sv/ale_pkg.sv -----
// ale_pkg: shared types and codes for the array list engine
// command and result beat structs, command and status codes, sizes
// no dependencies
package ale_pkg;

	localparam int unsigned ALE_CAPACITY = 128;
	localparam int unsigned ALE_ITEM_W   = 32;

	localparam logic [3:0] CMD_INSERT_AT   = 4'd0;
	localparam logic [3:0] CMD_APPEND      = 4'd1;
	localparam logic [3:0] CMD_APPEND_UNIQ = 4'd2;
	localparam logic [3:0] CMD_REMOVE_AT   = 4'd3;
	localparam logic [3:0] CMD_REMOVE_ITEM = 4'd4;
	localparam logic [3:0] CMD_READ        = 4'd5;
	localparam logic [3:0] CMD_REPLACE     = 4'd6;
	localparam logic [3:0] CMD_SEARCH      = 4'd7;
	localparam logic [3:0] CMD_CLEAR       = 4'd8;
	localparam logic [3:0] CMD_SORT        = 4'd9;
	localparam logic [3:0] CMD_COMPARE_AT  = 4'd10;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_OUT_RANGE = 3'd1;
	localparam logic [2:0] ST_FULL      = 3'd2;
	localparam logic [2:0] ST_DUPLICATE = 3'd3;
	localparam logic [2:0] ST_EMPTY     = 3'd4;
	localparam logic [2:0] ST_NOT_FOUND = 3'd5;

	typedef struct packed {
		logic [3:0]            command;
		logic [7:0]            position;
		logic [ALE_ITEM_W-1:0] item;
	} ale_cmd_t;

	typedef struct packed {
		logic [2:0]            status;
		logic [ALE_ITEM_W-1:0] read_item;
		logic                  found;
		logic [6:0]            found_position;
		logic [7:0]            list_length;
	} ale_res_t;

endpackage

// ----- sv/array_list_engine.sv -----
// array_list_engine: array list of words in one synchronous memory
// one command beat in, one result beat out, per command
// depends on ale_pkg
//
// The list lives in a single memory of CAPACITY words (one write and one read
// port, read data registered) plus a length counter. One command is worked on
// at a time; in_stall stays high from acceptance until the result sits in the
// output register, which lets the next command in while a result waits.
// Append, replace, clear, bad-position and full cases finish without a walk;
// read and compare go through a wait state for the registered read data; search
// and append_unique compare one entry per cycle through the read port;
// remove_item scans, then shifts down; insert_at and remove_at move one entry
// per cycle, read and write port both busy; sort is insertion sort walking
// the memory one compare at a time. The memory contents need no clearing
// after reset: only entries below the length are read and all of those were
// written.
module array_list_engine
	import ale_pkg::*;
#(
	parameter int unsigned CAPACITY = ALE_CAPACITY
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	input  ale_cmd_t in_data,
	output logic     out_valid,
	input  logic     out_stall,
	output ale_res_t out_data,
	input  logic     cfg_we,
	input  logic [7:0] cfg_data
);

	localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int unsigned CW = $clog2(CAPACITY + 1);
	localparam int unsigned XW = (CW > 8) ? CW : 8;

	// sequencer states
	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_SCAN = 4'd1;
	localparam logic [3:0] S_SHUP = 4'd2;
	localparam logic [3:0] S_SHDN = 4'd3;
	localparam logic [3:0] S_RDWT = 4'd4;
	localparam logic [3:0] S_SRTV = 4'd5;
	localparam logic [3:0] S_SRTC = 4'd6;
	localparam logic [3:0] S_SRTP = 4'd7;
	localparam logic [3:0] S_FIN  = 4'd8;

	// entry memory
	logic [ALE_ITEM_W-1:0] mem [CAPACITY];
	logic [ALE_ITEM_W-1:0] rdata;
	logic                  we;
	logic [AW-1:0]         wa, ra;
	logic [ALE_ITEM_W-1:0] wd;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		rdata <= mem[ra];
	end

	logic [3:0]            state_q, state_d;
	logic [3:0]            cmd_q, cmd_d;
	logic [7:0]            pos_q, pos_d;
	logic [ALE_ITEM_W-1:0] item_q, item_d;
	logic [CW-1:0]         cnt_q, cnt_d;
	logic [CW-1:0]         k_q, k_d;       // next read index of a walk
	logic                  go_q, go_d;     // insert walk still has reads left
	logic                  pend_s1, pend_d; // a read was issued last cycle
	logic [CW-1:0]         pidx_s1, pidx_d; // index of that read
	logic [CW-1:0]         i_q, i_d, j_q, j_d;
	logic [ALE_ITEM_W-1:0] v_q, v_d;
	ale_res_t              res_q, res_d;
	ale_res_t              out_q;
	logic                  out_valid_q;
	logic [7:0]            cap_q;
	logic                  out_load;

	// capacity register clamped to 1..CAPACITY
	logic [XW-1:0] cap_eff;
	always_comb begin
		cap_eff = XW'(cap_q);
		if (cap_q == 8'd0) begin
			cap_eff = XW'(1);
		end else if (XW'(cap_q) > XW'(CAPACITY)) begin
			cap_eff = XW'(CAPACITY);
		end
	end

	logic [XW-1:0] cnt_x, pos_x;
	logic          is_full;
	assign cnt_x   = XW'(cnt_q);
	assign pos_x   = XW'(in_data.position);
	assign is_full = (cnt_x >= cap_eff);

	assign in_stall = (state_q != S_IDLE);
	assign out_load = (state_q == S_FIN) && (!out_valid_q || !out_stall);

	always_comb begin
		state_d = state_q;
		cmd_d   = cmd_q;
		pos_d   = pos_q;
		item_d  = item_q;
		cnt_d   = cnt_q;
		k_d     = k_q;
		go_d    = go_q;
		pend_d  = 1'b0;
		pidx_d  = pidx_s1;
		i_d     = i_q;
		j_d     = j_q;
		v_d     = v_q;
		res_d   = res_q;
		we      = 1'b0;
		wa      = '0;
		wd      = '0;
		ra      = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd_d   = in_data.command;
					pos_d   = in_data.position;
					item_d  = in_data.item;
					res_d   = '0;
					state_d = S_FIN;
					k_d     = '0;
					case (in_data.command)
						CMD_INSERT_AT: begin
							if (pos_x > cnt_x) begin
								res_d.status = ST_OUT_RANGE;
							end else if (is_full) begin
								res_d.status = ST_FULL;
							end else begin
								k_d     = cnt_q - CW'(1);
								go_d    = (cnt_x > pos_x);
								state_d = S_SHUP;
							end
						end
						CMD_APPEND: begin
							if (is_full) begin
								res_d.status = ST_FULL;
							end else begin
								we    = 1'b1;
								wa    = cnt_q[AW-1:0];
								wd    = in_data.item;
								cnt_d = cnt_q + CW'(1);
							end
						end
						CMD_APPEND_UNIQ: begin
							if (is_full) begin
								res_d.status = ST_FULL;
							end else begin
								state_d = S_SCAN;
							end
						end
						CMD_REMOVE_AT: begin
							if (pos_x >= cnt_x) begin
								res_d.status = ST_OUT_RANGE;
							end else begin
								k_d     = CW'(pos_x) + CW'(1);
								state_d = S_SHDN;
							end
						end
						CMD_REMOVE_ITEM: begin
							if (cnt_q == '0) begin
								res_d.status = ST_EMPTY;
							end else begin
								state_d = S_SCAN;
							end
						end
						CMD_READ, CMD_COMPARE_AT: begin
							if (pos_x >= cnt_x) begin
								res_d.status = ST_OUT_RANGE;
							end else begin
								ra      = in_data.position[AW-1:0];
								state_d = S_RDWT;
							end
						end
						CMD_REPLACE: begin
							if (pos_x >= cnt_x) begin
								res_d.status = ST_OUT_RANGE;
							end else begin
								we = 1'b1;
								wa = in_data.position[AW-1:0];
								wd = in_data.item;
							end
						end
						CMD_SEARCH: begin
							state_d = S_SCAN;
						end
						CMD_CLEAR: begin
							cnt_d = '0;
						end
						CMD_SORT: begin
							if (cnt_q > CW'(1)) begin
								i_d     = CW'(1);
								ra      = AW'(1);
								state_d = S_SRTV;
							end
						end
						default: begin
						end
					endcase
				end
			end
			S_SCAN: begin
				if (pend_s1 && (rdata == item_q)) begin
					state_d = S_FIN;
					if (cmd_q == CMD_APPEND_UNIQ) begin
						res_d.status = ST_DUPLICATE;
					end else if (cmd_q == CMD_REMOVE_ITEM) begin
						k_d     = pidx_s1 + CW'(1);
						state_d = S_SHDN;
					end else begin
						res_d.found          = 1'b1;
						res_d.found_position = 7'(pidx_s1);
					end
				end else if (k_q < cnt_q) begin
					ra     = k_q[AW-1:0];
					pend_d = 1'b1;
					pidx_d = k_q;
					k_d    = k_q + CW'(1);
				end else begin
					state_d = S_FIN;
					if (cmd_q == CMD_APPEND_UNIQ) begin
						we    = 1'b1;
						wa    = cnt_q[AW-1:0];
						wd    = item_q;
						cnt_d = cnt_q + CW'(1);
					end else begin
						res_d.status = ST_NOT_FOUND;
					end
				end
			end
			S_SHUP: begin
				// reads walk down, each word written one place higher
				if (pend_s1) begin
					we = 1'b1;
					wa = AW'(pidx_s1 + CW'(1));
					wd = rdata;
				end
				if (go_q) begin
					ra     = k_q[AW-1:0];
					pend_d = 1'b1;
					pidx_d = k_q;
					if (XW'(k_q) == XW'(pos_q)) begin
						go_d = 1'b0;
					end else begin
						k_d = k_q - CW'(1);
					end
				end else if (!pend_s1) begin
					we      = 1'b1;
					wa      = pos_q[AW-1:0];
					wd      = item_q;
					cnt_d   = cnt_q + CW'(1);
					state_d = S_FIN;
				end
			end
			S_SHDN: begin
				// reads walk up, each word written one place lower
				if (pend_s1) begin
					we = 1'b1;
					wa = AW'(pidx_s1 - CW'(1));
					wd = rdata;
				end
				if (k_q < cnt_q) begin
					ra     = k_q[AW-1:0];
					pend_d = 1'b1;
					pidx_d = k_q;
					k_d    = k_q + CW'(1);
				end else if (!pend_s1) begin
					cnt_d   = cnt_q - CW'(1);
					state_d = S_FIN;
				end
			end
			S_RDWT: begin
				if (cmd_q == CMD_READ) begin
					res_d.read_item = rdata;
				end else begin
					res_d.found = (rdata == item_q);
				end
				state_d = S_FIN;
			end
			S_SRTV: begin
				v_d     = rdata;
				j_d     = i_q;
				ra      = AW'(i_q - CW'(1));
				state_d = S_SRTC;
			end
			S_SRTC: begin
				if (rdata > v_q) begin
					we  = 1'b1;
					wa  = j_q[AW-1:0];
					wd  = rdata;
					j_d = j_q - CW'(1);
					if (j_q >= CW'(2)) begin
						ra = AW'(j_q - CW'(2));
					end else begin
						state_d = S_SRTP;
					end
				end else begin
					we = 1'b1;
					wa = j_q[AW-1:0];
					wd = v_q;
					i_d = i_q + CW'(1);
					if ((i_q + CW'(1)) < cnt_q) begin
						ra      = AW'(i_q + CW'(1));
						state_d = S_SRTV;
					end else begin
						state_d = S_FIN;
					end
				end
			end
			S_SRTP: begin
				we  = 1'b1;
				wa  = '0;
				wd  = v_q;
				i_d = i_q + CW'(1);
				if ((i_q + CW'(1)) < cnt_q) begin
					ra      = AW'(i_q + CW'(1));
					state_d = S_SRTV;
				end else begin
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				if (out_load) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			go_q        <= 1'b0;
			pend_s1     <= 1'b0;
			out_valid_q <= 1'b0;
			cap_q       <= 8'd128;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			go_q    <= go_d;
			pend_s1 <= pend_d;
			if (cfg_we) begin
				cap_q <= cfg_data;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		cmd_q   <= cmd_d;
		pos_q   <= pos_d;
		item_q  <= item_d;
		k_q     <= k_d;
		pidx_s1 <= pidx_d;
		i_q     <= i_d;
		j_q     <= j_d;
		v_q     <= v_d;
		res_q   <= res_d;
		if (out_load) begin
			out_q <= {res_q.status, res_q.read_item, res_q.found,
				res_q.found_position, 8'(cnt_q)};
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// length never grows past the memory
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		XW'(cnt_q) <= XW'(CAPACITY))
		else $error("list length beyond capacity");

	// no new beat while a command is being worked on
	a_busy_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> in_stall)
		else $error("input taken while busy");

	// the memory is only written while a command is in progress
	a_write_ctx: assert property (@(posedge clk) disable iff (!arst_n)
		we |-> (state_q != S_FIN))
		else $error("memory write outside a command");

endmodule
